[sv/hmbs_pkg.sv]
// Shared constants and types for the height grid sampler.
package hmbs_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int BANK_DEPTH = (MAX_WIDTH * MAX_HEIGHT) / 4;
	localparam int BANK_AW    = COL_W + ROW_W - 2;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [2:0] {
		REG_GRID_WIDTH  = 3'd0,
		REG_GRID_HEIGHT = 3'd1,
		REG_X_TO_GRID   = 3'd2,
		REG_Y_TO_GRID   = 3'd3,
		REG_HEIGHT_STEP = 3'd4,
		REG_HEIGHT_MIN  = 3'd5
	} cfg_reg_t;

	localparam logic [8:0]  RST_GRID_WIDTH  = 9'd2;
	localparam logic [8:0]  RST_GRID_HEIGHT = 9'd2;
	localparam logic [31:0] RST_TO_GRID     = 32'd16777216;
	localparam logic [31:0] RST_HEIGHT_STEP = 32'd257;
	localparam logic [31:0] RST_HEIGHT_MIN  = 32'd0;

	typedef logic signed [25:0] grid_idx_t;
	typedef logic signed [41:0] sample_t;
	typedef logic [BANK_AW-1:0] bank_addr_t;

endpackage

[sv/hmbs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module hmbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/heightmap_bilinear_sampler.sv]
// Top level of the height grid sampler: config, banked grid and interpolation pipeline.
//
//  channel  | handshake       | payload
//  ---------+-----------------+---------------------------------------------------
//  item in  | start, busy     | kind, load_column, load_row, pixel_value, query_x/y
//  result   | done            | height_value
//  config   | cfg_we          | cfg_index, cfg_data
//
// One item is taken every cycle; busy is always low.
// A query gives its result as it leaves the last pipeline stage (s9); a load gives none.
// The grid lives in four banks split by row and column parity, so the four
// neighbors of a query are read in the same cycle. Loads write at the same stage.
// Reset clears control state only; grid entries are undefined until loaded.
// The receiver cannot stall, so nothing in the pipeline ever waits.
module heightmap_bilinear_sampler (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               kind,
	input  logic [7:0]         load_column,
	input  logic [7:0]         load_row,
	input  logic [7:0]         pixel_value,
	input  logic signed [31:0] query_x,
	input  logic signed [31:0] query_y,
	output logic               done,
	output logic signed [31:0] height_value,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	logic [8:0]  grid_width_q, grid_height_q;
	logic [31:0] x_to_grid_q, y_to_grid_q, height_step_q, height_min_q;

	logic qv_s1, qv_s2, qv_s3, qv_s4, qv_s5, qv_s6, qv_s7, qv_s8, qv_s9;
	logic lv_s1, lv_s2, lv_s3;

	logic [7:0]         col_s1, col_s2, col_s3;
	logic [7:0]         row_s1, row_s2, row_s3;
	logic [7:0]         pix_s1, pix_s2, pix_s3;
	logic signed [31:0] qx_s1, qy_s1;
	logic [63:0]        px_s2, py_s2;
	logic               nx_s2, ny_s2;
	hmbs_pkg::grid_idx_t c0_s3, r0_s3;
	logic [15:0]        fx_s3, fy_s3, fx_s4, fy_s4, fx_s5, fy_s5, fy_s6, fy_s7;
	logic               pc_s4, pr_s4;
	logic               vc0_s4, vc1_s4, vr0_s4, vr1_s4;
	hmbs_pkg::sample_t  samp_s5 [4];
	logic signed [59:0] prod_s6 [4];
	logic signed [44:0] top_s7, bot_s7;
	logic signed [62:0] pt_s8, pb_s8;

	assign busy = 1'b0;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= hmbs_pkg::RST_GRID_WIDTH;
			grid_height_q <= hmbs_pkg::RST_GRID_HEIGHT;
			x_to_grid_q   <= hmbs_pkg::RST_TO_GRID;
			y_to_grid_q   <= hmbs_pkg::RST_TO_GRID;
			height_step_q <= hmbs_pkg::RST_HEIGHT_STEP;
			height_min_q  <= hmbs_pkg::RST_HEIGHT_MIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hmbs_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg_data[8:0];
				hmbs_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg_data[8:0];
				hmbs_pkg::REG_X_TO_GRID:   x_to_grid_q   <= cfg_data;
				hmbs_pkg::REG_Y_TO_GRID:   y_to_grid_q   <= cfg_data;
				hmbs_pkg::REG_HEIGHT_STEP: height_step_q <= cfg_data;
				hmbs_pkg::REG_HEIGHT_MIN:  height_min_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{qv_s1, qv_s2, qv_s3, qv_s4, qv_s5, qv_s6, qv_s7, qv_s8, qv_s9} <= '0;
			{lv_s1, lv_s2, lv_s3} <= '0;
		end else begin
			qv_s1 <= start && !busy && (kind == hmbs_pkg::KIND_QUERY);
			lv_s1 <= start && !busy && (kind == hmbs_pkg::KIND_LOAD);
			qv_s2 <= qv_s1;
			qv_s3 <= qv_s2;
			qv_s4 <= qv_s3;
			qv_s5 <= qv_s4;
			qv_s6 <= qv_s5;
			qv_s7 <= qv_s6;
			qv_s8 <= qv_s7;
			qv_s9 <= qv_s8;
			lv_s2 <= lv_s1;
			lv_s3 <= lv_s2;
		end
	end

	assign done = qv_s9;

	// Stage 1: magnitude times scale.
	logic [31:0] mx_s1, my_s1;
	assign mx_s1 = qx_s1[31] ? (~qx_s1 + 32'd1) : qx_s1;
	assign my_s1 = qy_s1[31] ? (~qy_s1 + 32'd1) : qy_s1;

	// Stage 2: floor to grid units (Q.16).
	logic [64:0]        rx_s2, ry_s2;
	logic signed [41:0] gx_s2, gy_s2;
	assign rx_s2 = ({1'b0, px_s2} + 65'h0FFFFFF) >> 24;
	assign ry_s2 = ({1'b0, py_s2} + 65'h0FFFFFF) >> 24;
	assign gx_s2 = nx_s2 ? -$signed({1'b0, rx_s2[40:0]}) : $signed({2'b0, px_s2[63:24]});
	assign gy_s2 = ny_s2 ? -$signed({1'b0, ry_s2[40:0]}) : $signed({2'b0, py_s2[63:24]});

	// Stage 3: neighbor indexes, range checks, bank addresses and loads.
	logic [8:0]          wlim_s3, hlim_s3;
	hmbs_pkg::grid_idx_t c1_s3, r1_s3;
	logic                vc0_s3, vc1_s3, vr0_s3, vr1_s3;
	hmbs_pkg::grid_idx_t csel_s3 [2];
	hmbs_pkg::grid_idx_t rsel_s3 [2];
	hmbs_pkg::bank_addr_t raddr_s3 [4];
	hmbs_pkg::bank_addr_t waddr_s3;
	logic [hmbs_pkg::COL_W-1:0] lcol_s3;
	logic [hmbs_pkg::ROW_W-1:0] lrow_s3;
	logic                load_ok_s3;
	logic [7:0]          rdata_s4 [4];

	assign wlim_s3 = (int'(grid_width_q) < hmbs_pkg::MAX_WIDTH) ? grid_width_q
		: 9'(hmbs_pkg::MAX_WIDTH);
	assign hlim_s3 = (int'(grid_height_q) < hmbs_pkg::MAX_HEIGHT) ? grid_height_q
		: 9'(hmbs_pkg::MAX_HEIGHT);
	assign c1_s3  = c0_s3 + 26'sd1;
	assign r1_s3  = r0_s3 + 26'sd1;
	assign vc0_s3 = !c0_s3[25] && (c0_s3 < $signed({17'b0, wlim_s3}));
	assign vc1_s3 = !c1_s3[25] && (c1_s3 < $signed({17'b0, wlim_s3}));
	assign vr0_s3 = !r0_s3[25] && (r0_s3 < $signed({17'b0, hlim_s3}));
	assign vr1_s3 = !r1_s3[25] && (r1_s3 < $signed({17'b0, hlim_s3}));

	assign csel_s3[0] = c0_s3[0] ? c1_s3 : c0_s3;
	assign csel_s3[1] = c0_s3[0] ? c0_s3 : c1_s3;
	assign rsel_s3[0] = r0_s3[0] ? r1_s3 : r0_s3;
	assign rsel_s3[1] = r0_s3[0] ? r0_s3 : r1_s3;

	assign lcol_s3    = hmbs_pkg::COL_W'(col_s3);
	assign lrow_s3    = hmbs_pkg::ROW_W'(row_s3);
	assign load_ok_s3 = lv_s3 && (int'(col_s3) < hmbs_pkg::MAX_WIDTH)
		&& (int'(row_s3) < hmbs_pkg::MAX_HEIGHT);
	assign waddr_s3   = {lrow_s3[hmbs_pkg::ROW_W-1:1], lcol_s3[hmbs_pkg::COL_W-1:1]};

	for (genvar b = 0; b < 4; b++) begin : g_bank
		assign raddr_s3[b] = {rsel_s3[b / 2][hmbs_pkg::ROW_W-1:1],
			csel_s3[b % 2][hmbs_pkg::COL_W-1:1]};
		hmbs_ram #(
			.WIDTH(8),
			.DEPTH(hmbs_pkg::BANK_DEPTH)
		) u_bank (
			.clk  (clk),
			.we   (load_ok_s3 && (lrow_s3[0] == 1'(b / 2)) && (lcol_s3[0] == 1'(b % 2))),
			.waddr(waddr_s3),
			.wdata(pix_s3),
			.raddr(raddr_s3[b]),
			.rdata(rdata_s4[b])
		);
	end

	// Stage 4: pixels to heights; position k = 2*dy + dx sits in bank {pr^dy, pc^dx}.
	hmbs_pkg::sample_t samp_s4 [4];
	for (genvar k = 0; k < 4; k++) begin : g_samp
		logic [7:0] pix;
		logic       ok;
		assign pix = rdata_s4[{pr_s4 ^ 1'(k / 2), pc_s4 ^ 1'(k % 2)}];
		assign ok  = ((k % 2 == 0) ? vc0_s4 : vc1_s4) && ((k / 2 == 0) ? vr0_s4 : vr1_s4);
		assign samp_s4[k] = ok ? $signed({34'b0, pix}) * $signed({10'b0, height_step_q})
			+ 42'($signed(height_min_q)) : '0;
	end

	// Stage 5: blend weights along x.
	logic [16:0] wx_s5 [2];
	assign wx_s5[0] = 17'd65536 - {1'b0, fx_s5};
	assign wx_s5[1] = {1'b0, fx_s5};

	// Stage 6 and 8: sums with round half up.
	logic signed [60:0] st_s6, sb_s6;
	assign st_s6 = 61'(prod_s6[0]) + 61'(prod_s6[1]) + 61'sd32768;
	assign sb_s6 = 61'(prod_s6[2]) + 61'(prod_s6[3]) + 61'sd32768;

	logic signed [63:0] sh_s8;
	logic signed [47:0] h_s8;
	assign sh_s8 = 64'(pt_s8) + 64'(pb_s8) + 64'sd32768;
	assign h_s8  = sh_s8[63:16];

	always_ff @(posedge clk) begin
		col_s1 <= load_column;
		row_s1 <= load_row;
		pix_s1 <= pixel_value;
		qx_s1  <= query_x;
		qy_s1  <= query_y;

		col_s2 <= col_s1;
		row_s2 <= row_s1;
		pix_s2 <= pix_s1;
		px_s2  <= mx_s1 * x_to_grid_q;
		py_s2  <= my_s1 * y_to_grid_q;
		nx_s2  <= qx_s1[31];
		ny_s2  <= qy_s1[31];

		col_s3 <= col_s2;
		row_s3 <= row_s2;
		pix_s3 <= pix_s2;
		c0_s3  <= gx_s2[41:16];
		r0_s3  <= gy_s2[41:16];
		fx_s3  <= gx_s2[15:0];
		fy_s3  <= gy_s2[15:0];

		pc_s4  <= c0_s3[0];
		pr_s4  <= r0_s3[0];
		vc0_s4 <= vc0_s3;
		vc1_s4 <= vc1_s3;
		vr0_s4 <= vr0_s3;
		vr1_s4 <= vr1_s3;
		fx_s4  <= fx_s3;
		fy_s4  <= fy_s3;

		samp_s5 <= samp_s4;
		fx_s5   <= fx_s4;
		fy_s5   <= fy_s4;

		for (int k = 0; k < 4; k++) begin
			prod_s6[k] <= samp_s5[k] * $signed({1'b0, wx_s5[k % 2]});
		end
		fy_s6 <= fy_s5;

		top_s7 <= st_s6[60:16];
		bot_s7 <= sb_s6[60:16];
		fy_s7  <= fy_s6;

		pt_s8 <= top_s7 * $signed({1'b0, 17'd65536 - {1'b0, fy_s7}});
		pb_s8 <= bot_s7 * $signed({2'b0, fy_s7});

		if (h_s8 > 48'sh0000_7FFF_FFFF) begin
			height_value <= 32'sh7FFF_FFFF;
		end else if (h_s8 < -48'sh0000_8000_0000) begin
			height_value <= -32'sh8000_0000;
		end else begin
			height_value <= h_s8[31:0];
		end
	end

	a_query_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (kind == hmbs_pkg::KIND_QUERY) |-> ##9 done)
		else $error("query gave no result after nine cycles");

	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (kind == hmbs_pkg::KIND_LOAD) |-> ##9 !done)
		else $error("load gave a result");

	a_stage_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(qv_s3 && lv_s3))
		else $error("load and query share the bank access stage");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(qv_s4, 5))
		else $error("result without a query at the bank read stage");

endmodule

[tb/heightmap_bilinear_sampler_checker.sv]
// Checker for the height grid sampler: tracks config and grid, predicts and compares heights.
module heightmap_bilinear_sampler_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               kind,
	input  logic [7:0]         load_column,
	input  logic [7:0]         load_row,
	input  logic [7:0]         pixel_value,
	input  logic signed [31:0] query_x,
	input  logic signed [31:0] query_y,
	input  logic               done,
	input  logic signed [31:0] height_value,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output int                 errors,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0]         grid_px [hmbs_pkg::MAX_HEIGHT][hmbs_pkg::MAX_WIDTH];
	logic [8:0]         cols_used, rows_used;
	logic [31:0]        x_scale, y_scale, step;
	logic signed [31:0] base;
	logic signed [31:0] expected_heights [$];

	function automatic longint to_grid_units(logic signed [31:0] q, logic [31:0] s);
		logic signed [64:0] prod;
		prod = q * $signed({1'b0, s});
		return longint'(prod >>> 24);
	endfunction

	function automatic longint round_q16(longint v);
		return (v + 64'sd32768) >>> 16;
	endfunction

	function automatic longint grid_sample(longint col, longint row);
		longint w, h;
		w = (cols_used > hmbs_pkg::MAX_WIDTH) ? hmbs_pkg::MAX_WIDTH : cols_used;
		h = (rows_used > hmbs_pkg::MAX_HEIGHT) ? hmbs_pkg::MAX_HEIGHT : rows_used;
		if (col < 0 || row < 0 || col >= w || row >= h)
			return 0;
		return longint'(grid_px[row][col]) * longint'({32'b0, step}) + longint'(base);
	endfunction

	function automatic logic signed [31:0] height_at(logic signed [31:0] qx,
			logic signed [31:0] qy);
		longint gx, gy, c0, r0, fx, fy, upper, lower, h;
		gx = to_grid_units(qx, x_scale);
		gy = to_grid_units(qy, y_scale);
		c0 = gx >>> 16;
		r0 = gy >>> 16;
		fx = gx & 64'hFFFF;
		fy = gy & 64'hFFFF;
		upper = round_q16(grid_sample(c0, r0) * (65536 - fx) + grid_sample(c0 + 1, r0) * fx);
		lower = round_q16(grid_sample(c0, r0 + 1) * (65536 - fx)
			+ grid_sample(c0 + 1, r0 + 1) * fx);
		h = round_q16(upper * (65536 - fy) + lower * fy);
		if (h > 64'sd2147483647)
			h = 64'sd2147483647;
		if (h < -64'sd2147483648)
			h = -64'sd2147483648;
		return h[31:0];
	endfunction

	assign pending = expected_heights.size();

	always @(posedge clk or negedge arst_n) begin
		logic signed [31:0] want;
		if (!arst_n) begin
			cols_used = hmbs_pkg::RST_GRID_WIDTH;
			rows_used = hmbs_pkg::RST_GRID_HEIGHT;
			x_scale = hmbs_pkg::RST_TO_GRID;
			y_scale = hmbs_pkg::RST_TO_GRID;
			step = hmbs_pkg::RST_HEIGHT_STEP;
			base = hmbs_pkg::RST_HEIGHT_MIN;
			errors = 0;
			expected_heights.delete();
		end else begin
			if (done) begin
				if (expected_heights.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected height %0d at %0t", height_value, $time);
				end else begin
					want = expected_heights.pop_front();
					if (want !== height_value) begin
						errors++;
						if (errors <= 10)
							$display("height mismatch: expected %0d, got %0d at %0t",
								want, height_value, $time);
					end
				end
			end
			if (cfg_we) begin
				case (hmbs_pkg::cfg_reg_t'(cfg_index))
					hmbs_pkg::REG_GRID_WIDTH:  cols_used = cfg_data[8:0];
					hmbs_pkg::REG_GRID_HEIGHT: rows_used = cfg_data[8:0];
					hmbs_pkg::REG_X_TO_GRID:   x_scale = cfg_data;
					hmbs_pkg::REG_Y_TO_GRID:   y_scale = cfg_data;
					hmbs_pkg::REG_HEIGHT_STEP: step = cfg_data;
					hmbs_pkg::REG_HEIGHT_MIN:  base = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (kind == hmbs_pkg::KIND_LOAD)
					grid_px[load_row][load_column] = pixel_value;
				else
					expected_heights.push_back(height_at(query_x, query_y));
			end
		end
	end
endmodule

[tb/heightmap_bilinear_sampler_tb.sv]
// Testbench top for the height grid sampler: stimulus, config phases and verdict.
module heightmap_bilinear_sampler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               kind = hmbs_pkg::KIND_LOAD;
	logic [7:0]         load_column = '0;
	logic [7:0]         load_row = '0;
	logic [7:0]         pixel_value = '0;
	logic signed [31:0] query_x = '0;
	logic signed [31:0] query_y = '0;
	logic               done;
	logic signed [31:0] height_value;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = hmbs_pkg::REG_GRID_WIDTH;
	logic [31:0]        cfg_data = '0;
	int                 errors;
	int                 pending;
	int                 cycles = 0;
	bit                 steady = 1'b0;
	logic [8:0]         cols_now = hmbs_pkg::RST_GRID_WIDTH;
	logic [8:0]         rows_now = hmbs_pkg::RST_GRID_HEIGHT;
	logic [31:0]        xs_now = hmbs_pkg::RST_TO_GRID, ys_now = hmbs_pkg::RST_TO_GRID;

	always #2 clk = ~clk;

	heightmap_bilinear_sampler dut (.*);
	heightmap_bilinear_sampler_checker checker_i (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > 1000000) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic issue(logic k, logic [7:0] c, logic [7:0] r, logic [7:0] p,
			logic [31:0] x, logic [31:0] y);
		if (!steady && $urandom_range(99) < 16) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		kind <= k;
		load_column <= c;
		load_row <= r;
		pixel_value <= p;
		query_x <= x;
		query_y <= y;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(hmbs_pkg::cfg_reg_t idx, logic [31:0] value);
		start <= 1'b0;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			hmbs_pkg::REG_GRID_WIDTH:  cols_now = value[8:0];
			hmbs_pkg::REG_GRID_HEIGHT: rows_now = value[8:0];
			hmbs_pkg::REG_X_TO_GRID:   xs_now = value;
			hmbs_pkg::REG_Y_TO_GRID:   ys_now = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic settle();
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	// Map a grid position in Q16 units back to a world coordinate for the given scale.
	function automatic logic [31:0] world_of(longint g, logic [31:0] s);
		longint w;
		if (s == 0)
			return $urandom;
		w = (g <<< 24) / longint'({32'b0, s});
		if (w > 64'sd2147483647)
			w = 64'sd2147483647;
		if (w < -64'sd2147483648)
			w = -64'sd2147483648;
		return w[31:0];
	endfunction

	task automatic random_query();
		longint gx, gy, w, h;
		w = (cols_now > hmbs_pkg::MAX_WIDTH) ? hmbs_pkg::MAX_WIDTH : cols_now;
		h = (rows_now > hmbs_pkg::MAX_HEIGHT) ? hmbs_pkg::MAX_HEIGHT : rows_now;
		if ($urandom_range(99) < 15) begin
			issue(hmbs_pkg::KIND_QUERY, 8'($urandom), 8'($urandom), 8'($urandom),
				$urandom, $urandom);
		end else begin
			gx = longint'($urandom_range((w + 2) * 65536)) - 65536;
			gy = longint'($urandom_range((h + 2) * 65536)) - 65536;
			if ($urandom_range(3) == 0)
				gx = gx & ~64'hFFFF;
			issue(hmbs_pkg::KIND_QUERY, 8'($urandom), 8'($urandom), 8'($urandom),
				world_of(gx, xs_now), world_of(gy, ys_now));
		end
	endtask

	initial begin
		logic [31:0] corner [6];
		corner = '{32'h0, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000, 32'h7FFF_FFFF,
			32'h8000_0000};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Fill the first two rows and a 16 by 16 corner; grid sizes stay within them.
		steady = 1'b1;
		for (int r = 0; r < 16; r++)
			for (int c = 0; c < hmbs_pkg::MAX_WIDTH; c++)
				if (r < 2 || c < 16)
					issue(hmbs_pkg::KIND_LOAD, 8'(c), 8'(r), 8'($urandom), $urandom,
						$urandom);
		steady = 1'b0;

		issue(hmbs_pkg::KIND_LOAD, 8'd0, 8'd0, 8'd255, 32'h0, 32'h0);
		issue(hmbs_pkg::KIND_LOAD, 8'd1, 8'd1, 8'd0, 32'h0, 32'h0);
		issue(hmbs_pkg::KIND_LOAD, 8'd255, 8'd255, 8'd128, 32'h0, 32'h0);
		foreach (corner[i])
			foreach (corner[j])
				if (i < 3 || j < 3 || i == j)
					issue(hmbs_pkg::KIND_QUERY, 8'd0, 8'd0, 8'd0, corner[i], corner[j]);
		settle();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin
					write_reg(hmbs_pkg::REG_GRID_WIDTH, 32'd16);
					write_reg(hmbs_pkg::REG_GRID_HEIGHT, 32'd16);
					write_reg(hmbs_pkg::REG_X_TO_GRID, 32'h0100_0000);
					write_reg(hmbs_pkg::REG_Y_TO_GRID, 32'h0080_0000);
					write_reg(hmbs_pkg::REG_HEIGHT_STEP, 32'h0001_0000);
					write_reg(hmbs_pkg::REG_HEIGHT_MIN, 32'hFFF0_0000);
				end
				1: begin
					write_reg(hmbs_pkg::REG_GRID_WIDTH, 32'd2);
					write_reg(hmbs_pkg::REG_GRID_HEIGHT, 32'd16);
					write_reg(hmbs_pkg::REG_HEIGHT_STEP, 32'hFFFF_FFFF);
					write_reg(hmbs_pkg::REG_HEIGHT_MIN, 32'h7FFF_FFFF);
				end
				2: begin
					write_reg(hmbs_pkg::REG_GRID_WIDTH, 32'd300);
					write_reg(hmbs_pkg::REG_GRID_HEIGHT, 32'd2);
					write_reg(hmbs_pkg::REG_X_TO_GRID, 32'h0);
					write_reg(hmbs_pkg::REG_Y_TO_GRID, 32'hFFFF_FFFF);
					write_reg(hmbs_pkg::REG_HEIGHT_STEP, 32'h0);
					write_reg(hmbs_pkg::REG_HEIGHT_MIN, 32'h8000_0000);
				end
				3: begin
					write_reg(hmbs_pkg::REG_X_TO_GRID, 32'hFFFF_FFFF);
					write_reg(hmbs_pkg::REG_Y_TO_GRID, 32'h0);
					write_reg(hmbs_pkg::REG_HEIGHT_STEP, 32'hFFFF_FFFF);
					write_reg(hmbs_pkg::REG_HEIGHT_MIN, 32'h8000_0000);
				end
				default: begin
					if (phase == 6) begin
						write_reg(hmbs_pkg::REG_GRID_WIDTH, $urandom_range(257, 511));
						write_reg(hmbs_pkg::REG_GRID_HEIGHT, 32'd2);
					end else begin
						write_reg(hmbs_pkg::REG_GRID_WIDTH, $urandom_range(2, 16));
						write_reg(hmbs_pkg::REG_GRID_HEIGHT, $urandom_range(2, 16));
					end
					write_reg(hmbs_pkg::REG_X_TO_GRID, $urandom);
					write_reg(hmbs_pkg::REG_Y_TO_GRID, $urandom_range(32'h0400_0000));
					write_reg(hmbs_pkg::REG_HEIGHT_STEP, $urandom_range(32'h0004_0000));
					write_reg(hmbs_pkg::REG_HEIGHT_MIN, $urandom);
				end
			endcase
			steady = (phase == 5);
			for (int n = 0; n < 110; n++) begin
				if ($urandom_range(99) < 20)
					issue(hmbs_pkg::KIND_LOAD, 8'($urandom), 8'($urandom), 8'($urandom),
						$urandom, $urandom);
				else
					random_query();
			end
			steady = 1'b0;
			settle();
		end

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

[sim.f]
sv/hmbs_pkg.sv
sv/hmbs_ram.sv
sv/heightmap_bilinear_sampler.sv
tb/heightmap_bilinear_sampler_checker.sv
tb/heightmap_bilinear_sampler_tb.sv
